/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/scs_pkg.sv */
package scs_pkg;

    localparam int POSITIONS_DEF = 192;
    localparam int WEIGHT_DEF    = 52;
    localparam int SYMBOLS       = 4;
    localparam int POS_BYTES     = 1;
    localparam int POS_MASK      = 255;
    localparam int SYM_MASK      = 3;
    localparam int BYTE_W        = 8;
    localparam int PART_W        = 16;
    localparam int POS_OUT_W     = 8;
    localparam int SYM_OUT_W     = 2;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // queued item, symbol check already done in the front
    typedef struct packed {
        logic              start_req;
        logic [BYTE_W-1:0] xof_byte;
        logic              sym_ok;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

endpackage

/* hw/rtl/scs_front.sv */
`include "assert_macros.svh"

module scs_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_start_req,
    input  logic [7:0]                i_xof_byte,
    output scs_pkg::t_queue_head      o_head,
    input  logic                      i_pop
);

    localparam int QCNT_W = scs_pkg::QCNT_W;

    scs_pkg::t_item                       r_mem [scs_pkg::QUEUE_DEPTH];
    logic [scs_pkg::QPTR_W-1:0]           r_wr_ptr, n_wr_ptr;
    logic [scs_pkg::QPTR_W-1:0]           r_rd_ptr, n_rd_ptr;
    logic [scs_pkg::QCNT_W-1:0]           r_count, n_count;
    scs_pkg::t_item                       w_item;
    logic [7:0]                           w_sym;
    logic                                 w_push;
    logic                                 w_pop;

    // classify: masked symbol must land in 1..SYMBOLS-1
    always_comb begin
        w_sym            = i_xof_byte & 8'(scs_pkg::SYM_MASK);
        w_item.start_req = i_start_req;
        w_item.xof_byte  = i_xof_byte;
        w_item.sym_ok    = (w_sym != 8'd0) && (32'(w_sym) <= scs_pkg::SYMBOLS - 1);
    end

    assign o_ready     = (32'(r_count) != scs_pkg::QUEUE_DEPTH);
    assign w_push      = i_valid && o_ready;
    assign w_pop       = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QCNT_W'(w_push) - QCNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    `ASSERT_CLK(a_queue_bound, i_clk, i_rst_n, 32'(r_count) <= scs_pkg::QUEUE_DEPTH, "queue overfilled")
    `ASSERT_CLK(a_queue_count, i_clk, i_rst_n, (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1), "queue count lost a push")

endmodule

/* hw/rtl/scs_back.sv */
`include "assert_macros.svh"

module scs_back #(
    parameter int POSITIONS = scs_pkg::POSITIONS_DEF,
    parameter int WEIGHT    = scs_pkg::WEIGHT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  scs_pkg::t_queue_head i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_position,
    output logic [1:0]           o_symbol,
    output logic                 o_last
);

    localparam int PIDX_W = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
    localparam int CNT_W  = $clog2(WEIGHT + 1);
    localparam int PART_W = scs_pkg::PART_W;

    logic [POSITIONS-1:0] r_taken, n_taken;
    logic                 r_want_sym, n_want_sym;
    logic                 r_byte_cnt, n_byte_cnt;
    logic [PART_W-1:0]    r_partial, n_partial;
    logic [PIDX_W-1:0]    r_held, n_held;
    logic [CNT_W-1:0]     r_placed, n_placed;
    logic                 r_finished, n_finished;
    logic                 r_out_valid;
    logic [7:0]           r_position;
    logic [1:0]           r_symbol;
    logic                 r_last;

    logic                 w_step;
    logic                 w_emit;
    logic                 w_last;
    logic                 w_start;
    logic                 w_want_eff, w_cnt_eff, w_fin_eff;
    logic [PART_W-1:0]    w_part_eff, w_part_new, w_byte_sh;
    logic [CNT_W-1:0]     w_placed_eff;
    logic [CNT_W:0]       w_placed_inc;
    logic [PART_W-1:0]    w_pos;
    logic [PIDX_W-1:0]    w_idx;
    logic                 w_in_range, w_pos_free;
    logic [PART_W-1:0]    w_held_ext;
    logic [7:0]           w_sym_m;

    assign w_step = i_head.valid && (!r_out_valid || i_ready);
    assign o_pop  = w_step;
    assign w_start = i_head.item.start_req;

    always_comb begin
        // a start byte sees freshly cleared state
        w_want_eff   = w_start ? 1'b0 : r_want_sym;
        w_cnt_eff    = w_start ? 1'b0 : r_byte_cnt;
        w_fin_eff    = w_start ? 1'b0 : r_finished;
        w_part_eff   = w_start ? '0 : r_partial;
        w_placed_eff = w_start ? '0 : r_placed;

        w_byte_sh  = w_cnt_eff ? {i_head.item.xof_byte, 8'h00}
                               : {8'h00, i_head.item.xof_byte};
        w_part_new = w_part_eff | w_byte_sh;
        w_pos      = w_part_new & PART_W'(scs_pkg::POS_MASK);
        w_in_range = (32'(w_pos) < POSITIONS);
        w_idx      = w_pos[PIDX_W-1:0];
        w_pos_free = w_in_range && !(!w_start && r_taken[w_idx]);

        w_placed_inc = {1'b0, w_placed_eff} + 1'b1;
        w_last       = (32'(w_placed_inc) >= WEIGHT);
        w_held_ext   = PART_W'(r_held);
        w_sym_m      = i_head.item.xof_byte & 8'(scs_pkg::SYM_MASK);

        n_taken    = w_start ? '0 : r_taken;
        n_want_sym = w_want_eff;
        n_byte_cnt = w_cnt_eff;
        n_partial  = w_part_eff;
        n_held     = r_held;
        n_placed   = w_placed_eff;
        n_finished = w_fin_eff;
        w_emit     = 1'b0;

        if (!w_fin_eff) begin
            if (!w_want_eff) begin
                if (32'(w_cnt_eff) + 1 >= scs_pkg::POS_BYTES) begin
                    n_byte_cnt = 1'b0;
                    n_partial  = '0;
                    if (w_pos_free) begin
                        n_held     = w_idx;
                        n_want_sym = 1'b1;
                    end
                end else begin
                    n_byte_cnt = ~w_cnt_eff;
                    n_partial  = w_part_new;
                end
            end else if (i_head.item.sym_ok) begin
                n_taken[r_held] = 1'b1;
                n_placed        = w_placed_inc[CNT_W-1:0];
                n_finished      = w_last;
                n_want_sym      = 1'b0;
                w_emit          = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken     <= '0;
            r_want_sym  <= 1'b0;
            r_byte_cnt  <= 1'b0;
            r_partial   <= '0;
            r_placed    <= '0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_taken    <= n_taken;
                r_want_sym <= n_want_sym;
                r_byte_cnt <= n_byte_cnt;
                r_partial  <= n_partial;
                r_placed   <= n_placed;
                r_finished <= n_finished;
            end
            if (w_step && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_held <= n_held;
        end
        if (w_step && w_emit) begin
            r_position <= w_held_ext[7:0];
            r_symbol   <= w_sym_m[1:0];
            r_last     <= w_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_position = r_position;
    assign o_symbol   = r_symbol;
    assign o_last     = r_last;

    `ASSERT_CLK(a_fin_count, i_clk, i_rst_n, r_finished |-> (32'(r_placed) == WEIGHT), "finished before weight reached")
    `ASSERT_CLK(a_held_range, i_clk, i_rst_n, r_want_sym |-> (32'(r_held) < POSITIONS), "held position out of range")
    `ASSERT_CLK(a_emit_marks, i_clk, i_rst_n, (w_step && w_emit) |=> r_taken[$past(r_held)], "placed position not marked taken")
    `ASSERT_CLK(a_last_fin, i_clk, i_rst_n, (w_step && w_emit && w_last) |=> (r_finished && o_valid), "last entry did not finish")

endmodule

/* hw/rtl/sparse_challenge_sampler.sv */
// Sparse challenge sampler: rejection sampling over an XOF byte stream.
// Input channel (i_valid / o_ready): one item per byte, i_xof_byte plus
// i_start_req, which clears the taken-position map and counters before the
// byte is used. Output channel (o_valid / i_ready): one item per placed
// entry with o_position, o_symbol and o_last (high on the WEIGHT-th entry;
// later bytes are dropped until the next start).
// Bytes enter a 2-entry queue; the back end consumes one byte per cycle
// while the output register is free or being taken, updating a flop-based
// taken map, and registers any result. The byte that completes a result
// passes through the queue and then the output register that drives o_valid.
// Throughput: 1 byte per cycle while the receiver takes results.
// Receiver stall: the output register holds the result and the back end
// stops; the queue absorbs up to 2 more bytes before o_ready drops.
// Reset (synchronous, active low): leaves the same state as a start, with
// the queue and output register empty; no clearing pass is needed.
module sparse_challenge_sampler #(
    parameter int POSITIONS = scs_pkg::POSITIONS_DEF,
    parameter int WEIGHT    = scs_pkg::WEIGHT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_start_req,
    input  logic [7:0] i_xof_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_position,
    output logic [1:0] o_symbol,
    output logic       o_last
);

    scs_pkg::t_queue_head w_head;
    logic                 w_pop;

    scs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_start_req (i_start_req),
        .i_xof_byte  (i_xof_byte),
        .o_head      (w_head),
        .i_pop       (w_pop)
    );

    scs_back #(
        .POSITIONS (POSITIONS),
        .WEIGHT    (WEIGHT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_position (o_position),
        .o_symbol   (o_symbol),
        .o_last     (o_last)
    );

endmodule
